@@ rtl/ihp_pkg.sv @@
// ============================================================================
// ihp_pkg
// Types and constants shared by the interest header parser modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ihp_pkg;

    localparam int unsigned DEFAULT_NAME_BYTES = 16;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NUM_W    = 28;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // Output tdata: name_byte, status, name_length, chunk, left, right, ask.
    localparam int unsigned RES_BITS = 2 * BYTE_W + STATUS_W + 3 * NUM_W + 1;
    localparam int unsigned OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NOCACHE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ASK_MASK = 1'd1;

    // Header byte layout.
    localparam int unsigned HDR_CACHE_BIT = 1;
    localparam logic [1:0] MODE_DEFAULT = 2'd0;
    localparam logic [1:0] MODE_LENGTH  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FORWARD     = 2'd1,
        ST_RESERVED    = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } t_status;

    typedef enum logic {
        KIND_NAME    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_NAMELEN = 3'd1,
        PH_NAME    = 3'd2,
        PH_CHUNK   = 3'd3,
        PH_FLAG    = 3'd4,
        PH_LEFT    = 3'd5,
        PH_RIGHT   = 3'd6
    } t_phase;

    typedef struct packed {
        logic              nocache_value;
        logic [BYTE_W-1:0] ask_info_mask;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] name_byte;
        t_status           status;
        logic [BYTE_W-1:0] name_length;
        logic [NUM_W-1:0]  chunk_seq;
        logic [NUM_W-1:0]  first_off;
        logic [NUM_W-1:0]  last_off;
        logic              info_req;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/ihp_parse.sv @@
// ============================================================================
// ihp_parse
// Parser state and per-byte update. Consumes one registered byte per cycle
// while i_fire is high and produces at most one result item for it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ihp_parse
    import ihp_pkg::*;
#(
    parameter int unsigned NAME_BYTES = DEFAULT_NAME_BYTES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_start,
    input  wire logic              i_ask_req,
    input  wire t_cfg              i_cfg,
    output logic                   o_res_valid,
    output t_result                o_res
);

    t_phase            r_phase,       n_phase;
    logic [BYTE_W-1:0] r_bytes_left,  n_bytes_left;
    logic [BYTE_W-1:0] r_name_count,  n_name_count;
    logic [NUM_W-1:0]  r_accum,       n_accum;
    logic [1:0]        r_nbl,         n_nbl;
    logic [NUM_W-1:0]  r_chunk,       n_chunk;
    logic [NUM_W-1:0]  r_left,        n_left;
    logic              r_ask,         n_ask;

    logic              num_done;
    logic              num_bad;
    logic [NUM_W-1:0]  num_val;
    logic [NUM_W-1:0]  num_accum;
    logic [1:0]        num_nbl;
    logic              forward;
    logic [1:0]        mode;
    logic              in_number;

    assign mode      = i_byte[3:2];
    assign forward   = (i_byte[HDR_CACHE_BIT] == i_cfg.nocache_value);
    assign in_number = (r_phase == PH_CHUNK) || (r_phase == PH_LEFT) || (r_phase == PH_RIGHT);

    // Prefix-coded number: the first byte's leading ones give the count of
    // bytes that follow; later bytes shift in from the bottom.
    always_comb begin
        num_done  = 1'b0;
        num_bad   = 1'b0;
        num_val   = NUM_W'(i_byte);
        num_accum = r_accum;
        num_nbl   = r_nbl;
        if (r_nbl == 2'd0) begin
            if (!i_byte[7]) begin
                num_done = 1'b1;
            end else if (i_byte[7:6] == 2'b10) begin
                num_accum = NUM_W'(i_byte[5:0]);
                num_nbl   = 2'd1;
            end else if (i_byte[7:5] == 3'b110) begin
                num_accum = NUM_W'(i_byte[4:0]);
                num_nbl   = 2'd2;
            end else if (i_byte[7:4] == 4'b1110) begin
                num_accum = NUM_W'(i_byte[3:0]);
                num_nbl   = 2'd3;
            end else begin
                num_bad = 1'b1;
            end
        end else begin
            num_accum = {r_accum[NUM_W-BYTE_W-1:0], i_byte};
            num_nbl   = r_nbl - 2'd1;
            if (r_nbl == 2'd1) begin
                num_done = 1'b1;
                num_val  = num_accum;
            end
        end
    end

    // Next state.
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_name_count = r_name_count;
        n_accum      = r_accum;
        n_nbl        = r_nbl;
        n_chunk      = r_chunk;
        n_left       = r_left;
        n_ask        = r_ask;
        if (i_fire) begin
            if (i_start) begin
                n_name_count = '0;
                n_accum      = '0;
                n_nbl        = '0;
                n_chunk      = '0;
                n_left       = '0;
                n_bytes_left = '0;
                n_ask        = i_ask_req;
                if (forward) begin
                    n_phase = PH_IDLE;
                end else if (mode == MODE_DEFAULT) begin
                    n_bytes_left = BYTE_W'(NAME_BYTES);
                    n_phase      = PH_NAME;
                end else if (mode == MODE_LENGTH) begin
                    n_phase = PH_NAMELEN;
                end else begin
                    n_phase = PH_IDLE;
                end
            end else begin
                case (r_phase)
                    PH_NAMELEN: begin
                        n_bytes_left = i_byte;
                        n_phase      = (i_byte == '0) ? PH_CHUNK : PH_NAME;
                    end
                    PH_NAME: begin
                        n_name_count = r_name_count + 1'b1;
                        n_bytes_left = r_bytes_left - 1'b1;
                        if (r_bytes_left == BYTE_W'(1)) begin
                            n_phase = PH_CHUNK;
                        end
                    end
                    PH_FLAG: begin
                        if ((i_byte & i_cfg.ask_info_mask) != '0) begin
                            n_ask = 1'b1;
                        end
                        n_phase = PH_LEFT;
                    end
                    PH_CHUNK, PH_LEFT, PH_RIGHT: begin
                        if (num_bad) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_accum = num_accum;
                            n_nbl   = num_nbl;
                            if (num_done) begin
                                case (r_phase)
                                    PH_CHUNK: begin
                                        n_chunk = num_val;
                                        n_phase = PH_FLAG;
                                    end
                                    PH_LEFT: begin
                                        n_left  = num_val;
                                        n_phase = PH_RIGHT;
                                    end
                                    default: begin
                                        n_phase = PH_IDLE;
                                    end
                                endcase
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Result item.
    always_comb begin
        o_res_valid       = 1'b0;
        o_res             = '0;
        o_res.kind        = KIND_SUMMARY;
        o_res.name_length = r_name_count;
        o_res.chunk_seq   = r_chunk;
        o_res.first_off   = r_left;
        o_res.info_req    = r_ask;
        o_res.status      = ST_OK;
        if (i_start) begin
            // A header summary reports the freshly cleared values.
            o_res.name_length = '0;
            o_res.chunk_seq   = '0;
            o_res.first_off   = '0;
            o_res.info_req    = i_ask_req;
            if (forward) begin
                o_res_valid  = i_fire;
                o_res.status = ST_FORWARD;
            end else if ((mode != MODE_DEFAULT) && (mode != MODE_LENGTH)) begin
                o_res_valid  = i_fire;
                o_res.status = ST_RESERVED;
            end
        end else if (r_phase == PH_NAME) begin
            o_res_valid     = i_fire;
            o_res           = '0;
            o_res.kind      = KIND_NAME;
            o_res.name_byte = i_byte;
        end else if (in_number && num_bad) begin
            o_res_valid  = i_fire;
            o_res.status = ST_UNSUPPORTED;
        end else if ((r_phase == PH_RIGHT) && num_done) begin
            o_res_valid    = i_fire;
            o_res.last_off = num_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= '0;
            r_name_count <= '0;
            r_accum      <= '0;
            r_nbl        <= '0;
            r_chunk      <= '0;
            r_left       <= '0;
            r_ask        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_name_count <= n_name_count;
            r_accum      <= n_accum;
            r_nbl        <= n_nbl;
            r_chunk      <= n_chunk;
            r_left       <= n_left;
            r_ask        <= n_ask;
        end
    end

`ifndef SYNTHESIS
    a_summary_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == KIND_SUMMARY)) |=> (r_phase == PH_IDLE))
        else $error("phase not idle after a summary item");

    a_name_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == KIND_NAME)) |-> (r_phase == PH_NAME))
        else $error("name item outside the name phase");

    a_nbl_in_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nbl != 2'd0) |-> in_number)
        else $error("number bytes pending outside a number field");
`endif

endmodule

`default_nettype wire

@@ rtl/ihp_out.sv @@
// ============================================================================
// ihp_out
// Output register with a skid stage, so the parser can hand over one more
// result while a finished result waits on the downstream side.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ihp_out
    import ihp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_result i_res,
    output logic      o_ready,
    output logic      o_valid,
    output t_result   o_res,
    input  wire logic i_ready
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    in_fire;

    assign o_ready = !r_skid_v;
    assign in_fire = i_valid && !r_skid_v;
    assign o_valid = r_main_v;
    assign o_res   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || i_ready) begin
            r_main_v <= r_skid_v || in_fire;
            r_skid_v <= 1'b0;
        end else if (in_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_v || i_ready) begin
            r_main <= r_skid_v ? r_skid : i_res;
        end else if (in_fire) begin
            r_skid <= i_res;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid stage holds an item while the output is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_ready) |=> !r_skid_v)
        else $error("skid stage did not drain");
`endif

endmodule

`default_nettype wire

@@ rtl/interest_header_parser.sv @@
// Path: an item that causes a result is held in the input register, then goes
// through the parser into the result register before it shows on the master side.
// Throughput: one byte per cycle while the output stage can take a result; the
// parser's state update sits between the input register and the result register.
// Reset: i_rst_n is synchronous and active low; it empties the input, output and
// skid registers, sets the parser idle and loads the configuration defaults.
// ============================================================================
// interest_header_parser
// Streams an interest carrier packet one byte per item and emits name bytes
// and a final parse summary.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module interest_header_parser
    import ihp_pkg::*;
#(
    parameter int unsigned NAME_BYTES = DEFAULT_NAME_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [BYTE_W-1:0]     i_s_axis_tdata,  // data_byte
    input  wire logic [1:0]            i_s_axis_tuser,  // packet_start, ask_request
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // name_byte, status, name_length, chunk sequence, first offset,
    // last offset, info request, zero fill
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                       o_m_axis_tuser,  // kind
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [BYTE_W-1:0]     i_cfg_data
);

    t_cfg              r_cfg;
    logic              r_in_v;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic              r_in_ask;

    logic    fire;
    logic    res_valid;
    t_result res;
    logic    out_ready;
    logic    out_valid;
    t_result out_res;

    assign o_cfg_ready     = 1'b1;
    assign fire            = r_in_v && out_ready;
    assign o_s_axis_tready = !r_in_v || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nocache_value <= 1'b0;
            r_cfg.ask_info_mask <= BYTE_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NOCACHE:  r_cfg.nocache_value <= i_cfg_data[0];
                CFG_ASK_MASK: r_cfg.ask_info_mask <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_start <= i_s_axis_tuser[0];
            r_in_ask   <= i_s_axis_tuser[1];
        end
    end

    ihp_parse #(
        .NAME_BYTES (NAME_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_ask_req   (r_in_ask),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ihp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (out_valid),
        .o_res   (out_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tuser  = out_res.kind;
    assign o_m_axis_tdata  = OUT_DATA_W'({out_res.info_req, out_res.last_off,
                                          out_res.first_off, out_res.chunk_seq,
                                          out_res.name_length, out_res.status,
                                          out_res.name_byte});

endmodule

`default_nettype wire
